// ===== sv/pptpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pptpb_pkg: shared types and constants of the trigger capture buffer
// Command codes, result kinds, register indexes and the controller/datapath
// interface structs.
// ----------------------------------------------------------------------------
package pptpb_pkg;

	localparam int TIME_BITS    = 48;
	localparam int CFG_BITS     = 10;
	localparam int CFG_IDX_BITS = 2;
	localparam int CMD_BITS     = 2;
	localparam int KIND_BITS    = 2;
	localparam int BOUND_BITS   = 30;
	localparam int USEC_PER_SEC = 1000000;

	localparam logic [CMD_BITS-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_ON   = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_OFF  = 2'd2;

	localparam logic [KIND_BITS-1:0] KIND_FWD  = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_OVF  = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_DONE = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PRE    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_POST   = 2'd2;

	// age limits held as (seconds + 1) * 1e6, ready for a direct compare
	localparam logic [BOUND_BITS-1:0] BOUND_WINDOW_RST = 30'd61000000;
	localparam logic [BOUND_BITS-1:0] BOUND_PRE_RST    = 30'd21000000;
	localparam logic [BOUND_BITS-1:0] BOUND_POST_RST   = 30'd21000000;

	typedef struct packed {
		logic                 load;
		logic                 drop;
		logic                 store;
		logic                 emit;
		logic [KIND_BITS-1:0] kind;
		logic                 from_rd;
		logic                 zero_tag;
		logic                 is_last;
		logic                 post_chk;
		logic                 set_trig;
		logic                 set_off;
	} pptpb_cmd_t;

	typedef struct packed {
		logic out_free;
		logic empty;
		logic full;
		logic trig;
		logic exc_win;
		logic exc_pre;
	} pptpb_sts_t;

	function automatic logic [BOUND_BITS-1:0] bound_of(input logic [CFG_BITS-1:0] secs);
		logic [BOUND_BITS-1:0] s;
		s = BOUND_BITS'(secs) + BOUND_BITS'(1);
		bound_of = s * BOUND_BITS'(USEC_PER_SEC);
	endfunction

endpackage

// ===== sv/pptpb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pptpb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pptpb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/pptpb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pptpb_ctrl: sequencing state machine
// Walks the queue head for window drops and trigger-on flushes, and issues
// store, emit and trigger commands to the datapath.
// ----------------------------------------------------------------------------
module pptpb_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pptpb_pkg::CMD_BITS-1:0] cmd,
	input  pptpb_pkg::pptpb_sts_t         sts,
	output pptpb_pkg::pptpb_cmd_t         ctl
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PUSH  = 2'd1;
	localparam logic [1:0] S_FLUSH = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ctl.load = 1'b1;
					case (cmd)
						pptpb_pkg::CMD_PUSH: state_d = S_PUSH;
						pptpb_pkg::CMD_ON:   state_d = S_FLUSH;
						pptpb_pkg::CMD_OFF:  ctl.set_off = 1'b1;
						default:             ;
					endcase
				end
			end
			S_PUSH: begin
				if (!sts.empty && sts.exc_win) begin
					ctl.drop = 1'b1;
				end else if (sts.trig) begin
					if (sts.out_free) begin
						ctl.emit     = 1'b1;
						ctl.kind     = pptpb_pkg::KIND_FWD;
						ctl.is_last  = 1'b1;
						ctl.post_chk = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (sts.full) begin
					// evict the oldest and reuse its slot in the same cycle
					if (sts.out_free) begin
						ctl.emit     = 1'b1;
						ctl.kind     = pptpb_pkg::KIND_OVF;
						ctl.from_rd  = 1'b1;
						ctl.is_last  = 1'b1;
						ctl.drop     = 1'b1;
						ctl.store    = 1'b1;
						ctl.post_chk = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					ctl.store    = 1'b1;
					ctl.post_chk = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (sts.empty) begin
					state_d = S_DONE;
				end else if (sts.exc_pre) begin
					ctl.drop = 1'b1;
				end else if (sts.out_free) begin
					ctl.emit    = 1'b1;
					ctl.kind    = pptpb_pkg::KIND_FWD;
					ctl.from_rd = 1'b1;
					ctl.drop    = 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					ctl.emit     = 1'b1;
					ctl.kind     = pptpb_pkg::KIND_DONE;
					ctl.zero_tag = 1'b1;
					ctl.is_last  = 1'b1;
					ctl.set_trig = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/pptpb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pptpb_dp: queue, trigger state and result register
// Ring queue of tag/time pairs in RAM, age compares, age limit registers and
// the output register of the result channel.
// ----------------------------------------------------------------------------
module pptpb_dp #(
	parameter int QUEUE_DEPTH = 32,
	parameter int TAG_BITS    = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pptpb_pkg::pptpb_cmd_t           ctl,
	output pptpb_pkg::pptpb_sts_t           sts,
	input  logic [pptpb_pkg::TIME_BITS-1:0] event_time,
	input  logic [TAG_BITS-1:0]             packet_tag,
	input  logic                            cfg_we,
	input  logic [pptpb_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [pptpb_pkg::CFG_BITS-1:0]  cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pptpb_pkg::KIND_BITS-1:0] result_kind,
	output logic [TAG_BITS-1:0]             out_tag,
	output logic                            last
);

	localparam int TB    = pptpb_pkg::TIME_BITS;
	localparam int BB    = pptpb_pkg::BOUND_BITS;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam int ENT_W = TAG_BITS + TB;

	logic [TB-1:0]       t_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [IDX_W-1:0]    head_q;
	logic [IDX_W-1:0]    head_d;
	logic [IDX_W-1:0]    head_inc;
	logic [IDX_W-1:0]    tail;
	logic [SUM_W-1:0]    tail_sum;
	logic [CNT_W-1:0]    count_q;
	logic                trig_q;
	logic                offp_q;
	logic [TB-1:0]       off_time_q;
	logic [BB-1:0]       bnd_win_q;
	logic [BB-1:0]       bnd_pre_q;
	logic [BB-1:0]       bnd_post_q;
	logic                out_valid_q;
	logic [pptpb_pkg::KIND_BITS-1:0] kind_q;
	logic [TAG_BITS-1:0] otag_q;
	logic                last_q;

	logic [ENT_W-1:0]    rdata;
	logic [TAG_BITS-1:0] rd_tag;
	logic [TB-1:0]       rd_time;
	logic [TB:0]         diff_head;
	logic [TB:0]         diff_off;
	logic                exc_post;
	logic                out_free;

	assign head_inc = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_d   = ctl.drop ? head_inc : head_q;
	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
	                  IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

	// read at the next head so the data of the current head is always on hand
	pptpb_ram #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.store),
		.waddr(tail),
		.wdata({tag_q, t_q}),
		.raddr(head_d),
		.rdata(rdata)
	);

	assign rd_tag  = rdata[ENT_W-1:TB];
	assign rd_time = rdata[TB-1:0];

	// a negative difference never exceeds a limit
	assign diff_head = {1'b0, t_q} - {1'b0, rd_time};
	assign diff_off  = {1'b0, t_q} - {1'b0, off_time_q};
	assign exc_post  = !diff_off[TB] && (diff_off[TB-1:0] >= TB'(bnd_post_q));

	assign out_free = !out_valid_q || out_ready;

	assign sts.out_free = out_free;
	assign sts.empty    = (count_q == '0);
	assign sts.full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign sts.trig     = trig_q;
	assign sts.exc_win  = !diff_head[TB] && (diff_head[TB-1:0] >= TB'(bnd_win_q));
	assign sts.exc_pre  = !diff_head[TB] && (diff_head[TB-1:0] >= TB'(bnd_pre_q));

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			t_q   <= event_time;
			tag_q <= packet_tag;
		end
		if (ctl.set_off) begin
			off_time_q <= event_time;
		end
		if (ctl.emit) begin
			kind_q <= ctl.kind;
			last_q <= ctl.is_last;
			if (ctl.zero_tag) begin
				otag_q <= '0;
			end else if (ctl.from_rd) begin
				otag_q <= rd_tag;
			end else begin
				otag_q <= tag_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			trig_q      <= 1'b0;
			offp_q      <= 1'b0;
			out_valid_q <= 1'b0;
			bnd_win_q   <= pptpb_pkg::BOUND_WINDOW_RST;
			bnd_pre_q   <= pptpb_pkg::BOUND_PRE_RST;
			bnd_post_q  <= pptpb_pkg::BOUND_POST_RST;
		end else begin
			head_q <= head_d;
			if (ctl.drop && !ctl.store) begin
				count_q <= count_q - 1'b1;
			end else if (ctl.store && !ctl.drop) begin
				count_q <= count_q + 1'b1;
			end
			if (ctl.set_trig) begin
				trig_q <= 1'b1;
				offp_q <= 1'b0;
			end else if (ctl.set_off) begin
				offp_q <= 1'b1;
			end else if (ctl.post_chk && offp_q && exc_post) begin
				trig_q <= 1'b0;
				offp_q <= 1'b0;
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					pptpb_pkg::REG_WINDOW: bnd_win_q  <= pptpb_pkg::bound_of(cfg_data);
					pptpb_pkg::REG_PRE:    bnd_pre_q  <= pptpb_pkg::bound_of(cfg_data);
					pptpb_pkg::REG_POST:   bnd_post_q <= pptpb_pkg::bound_of(cfg_data);
					default:               ;
				endcase
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign out_tag     = otag_q;
	assign last        = last_q;

endmodule

// ===== sv/pre_post_trigger_packet_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_post_trigger_packet_buffer: event-triggered packet capture buffer
// Queues packet tags with their timestamps while no trigger is active,
// forwards history on trigger-on and live packets until trigger-off expires.
// ----------------------------------------------------------------------------
//   channel   handshake               payload
//   input     in_valid / in_ready     cmd, event_time, packet_tag
//   result    out_valid / out_ready   result_kind, out_tag, last
//   config    cfg_we                  cfg_index, cfg_data
//
// Trigger-off and unused commands are taken without leaving the idle state.
// A push first drops queued packets too old for the window; a trigger-on
// walks the queue RAM one head entry per cycle, unless the output stalls.
// A result waits in the output register; a stalled output only holds the
// step that needs to emit. Reset empties the queue and clears the trigger.
// ----------------------------------------------------------------------------
module pre_post_trigger_packet_buffer #(
	parameter int QUEUE_DEPTH = 32,
	parameter int TAG_BITS    = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [pptpb_pkg::CMD_BITS-1:0]     cmd,
	input  logic [pptpb_pkg::TIME_BITS-1:0]    event_time,
	input  logic [TAG_BITS-1:0]                packet_tag,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [pptpb_pkg::KIND_BITS-1:0]    result_kind,
	output logic [TAG_BITS-1:0]                out_tag,
	output logic                               last,
	input  logic                               cfg_we,
	input  logic [pptpb_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [pptpb_pkg::CFG_BITS-1:0]     cfg_data
);

	pptpb_pkg::pptpb_cmd_t ctl;
	pptpb_pkg::pptpb_sts_t sts;

	pptpb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts),
		.ctl     (ctl)
	);

	pptpb_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TAG_BITS   (TAG_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.event_time (event_time),
		.packet_tag (packet_tag),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_kind(result_kind),
		.out_tag    (out_tag),
		.last       (last)
	);

endmodule

// ===== sv/pptpb_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pptpb_chk: port-level checks of the capture buffer
// Watches the top level ports; bound to the top level below.
// ----------------------------------------------------------------------------
module pptpb_chk #(
	parameter int TAG_BITS = 16
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic [pptpb_pkg::CMD_BITS-1:0]     cmd,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [pptpb_pkg::KIND_BITS-1:0]    result_kind,
	input logic [TAG_BITS-1:0]                out_tag,
	input logic                               last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
		$stable(out_tag) && $stable(last))
		else $error("result changed while stalled");

	// the done marker closes a trigger-on and carries no tag
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == pptpb_pkg::KIND_DONE) |-> last && (out_tag == '0))
		else $error("done marker without last or with a tag");

	// an eviction is the only result of its push
	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == pptpb_pkg::KIND_OVF) |-> last)
		else $error("overflow result without last");

	// a push or trigger-on keeps the input closed for its following cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready &&
		((cmd == pptpb_pkg::CMD_PUSH) || (cmd == pptpb_pkg::CMD_ON)) |=> !in_ready)
		else $error("input taken while queue walk pending");

endmodule

bind pre_post_trigger_packet_buffer pptpb_chk #(.TAG_BITS(TAG_BITS)) u_chk (.*);
